// ===== rtl/dwrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwrc_pkg
// Shared constants for the wall ray caster: map and walk defaults,
// register indexes, reset values and stream field widths.
// ----------------------------------------------------------------------------
package dwrc_pkg;

    localparam int MAP_WIDTH  = 32;
    localparam int MAP_HEIGHT = 32;
    localparam int TILE_SIZE  = 64;
    localparam int MAX_STEPS  = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd7;

    localparam logic signed [15:0] RST_DIR_X   = 16'sd16384;
    localparam logic signed [15:0] RST_DIR_Y   = 16'sd0;
    localparam logic signed [15:0] RST_PLANE_X = 16'sd0;
    localparam logic signed [15:0] RST_PLANE_Y = 16'sd10813;
    localparam logic [11:0]        RST_SCREEN_H = 12'd480;
    localparam logic [10:0]        RST_HALF_W   = 11'd320;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_CAST = 1'b1;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 112;

    // perp distance divisor width (|ray| up to 2^23)
    localparam int DEN_W = 24;

endpackage

// ===== rtl/dwrc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwrc_div
// Restoring divider, one quotient bit per cycle, shared by all divisions
// of the ray caster.
// ----------------------------------------------------------------------------
module dwrc_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = dwrc_pkg::DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [DEN_W:0]   trial;
    logic             q_bit;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        q_bit = (trial >= {1'b0, r_den});
        n_rem = q_bit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

// ===== rtl/dwrc_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwrc_map
// Tile map memory with registered read and a clearing pass after reset.
// ----------------------------------------------------------------------------
module dwrc_map #(
    parameter int DEPTH = dwrc_pkg::MAP_WIDTH * dwrc_pkg::MAP_HEIGHT,
    parameter int AW    = $clog2(dwrc_pkg::MAP_WIDTH * dwrc_pkg::MAP_HEIGHT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    output logic          o_busy
);
    logic [7:0]    mem [DEPTH];
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;
    logic [7:0]    r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1))
                r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy)
            mem[r_clr_addr] <= 8'd0;
        else if (i_wr_en)
            mem[i_wr_addr] <= i_wr_data;
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

// ===== rtl/dda_wall_ray_caster.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_wall_ray_caster
// Grid ray caster: builds one ray per screen column and walks the tile map.
// ----------------------------------------------------------------------------
// Input stream: tuser is the kind (load a tile or cast a column), tdata the
// tile coordinates, tile value and column. A load is written to the map as it is
// taken and gives no result. A cast gives one result on the output stream.
// A cast runs under a small sequencer around one shared divider (one bit a
// cycle), one shared multiplier and the map read port. A hit is offered on
// the output after the camera division, the grid walk, the perp distance and
// line height divisions and the texture product; a miss once the walk stops.
// DIV_N, the divider width, is 37 by default, and the walk visits at most
// MAX_STEPS grid cells. The input is not ready while a cast is in flight.
// Configuration writes go to the plain write port; the user must write them
// only while the block is idle, which the block does not enforce. After reset
// the tile map is cleared, one cell a cycle; no request is taken meanwhile.
// The result is held in the output register while the receiver stalls; the
// next request is taken once it has been delivered.
// ----------------------------------------------------------------------------
module dda_wall_ray_caster #(
    parameter int MAP_WIDTH  = dwrc_pkg::MAP_WIDTH,
    parameter int MAP_HEIGHT = dwrc_pkg::MAP_HEIGHT,
    parameter int TILE_SIZE  = dwrc_pkg::TILE_SIZE,
    parameter int MAX_STEPS  = dwrc_pkg::MAX_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dwrc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dwrc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tile_x[4:0], tile_y[9:5], tile_value[17:10], column[27:18]
    input  logic [dwrc_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // kind
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // column_out[9:0], side[10], wall_value[18:11], perp_distance[42:19],
    // line_height[58:43], draw_start[74:59], draw_end[90:75], tex_u[106:91]
    output logic [dwrc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // hit
    output logic                              o_m_tuser
);
    localparam int DEPTH   = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int X_W     = $clog2(MAP_WIDTH);
    localparam int Y_W     = $clog2(MAP_HEIGHT);
    localparam int P_W     = 27;
    localparam int CELL_W  = 14;
    localparam int NX_W    = $clog2(MAX_STEPS + 2) + 16;
    localparam int AB_W    = NX_W + 24;
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    localparam int DIV_N   = (NX_W + 14 > 28) ? NX_W + 14 : 28;
    localparam int DEN_W   = dwrc_pkg::DEN_W;

    typedef enum logic [18:0] {
        S_IDLE      = 19'h00001,
        S_CAM_GO    = 19'h00002,
        S_CAM_WAIT  = 19'h00004,
        S_MUL_RX    = 19'h00008,
        S_MUL_RY    = 19'h00010,
        S_RAY_Y     = 19'h00020,
        S_MUL_A     = 19'h00040,
        S_MUL_B     = 19'h00080,
        S_START     = 19'h00100,
        S_WALK      = 19'h00200,
        S_LOOK      = 19'h00400,
        S_MISS      = 19'h00800,
        S_PERP_GO   = 19'h01000,
        S_PERP_WAIT = 19'h02000,
        S_LH_GO     = 19'h04000,
        S_LH_WAIT   = 19'h08000,
        S_MUL_TEX   = 19'h10000,
        S_FINISH    = 19'h20000,
        S_OUT       = 19'h40000
    } t_state;

    function automatic logic signed [24:0] clamp_ray(input logic signed [39:0] v);
        if (v > 40'sd8388608)
            return 25'sd8388608;
        else if (v < -40'sd8388608)
            return -25'sd8388608;
        else
            return v[24:0];
    endfunction

    // configuration
    logic [18:0]        r_pos_x, r_pos_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [11:0]        r_scr_h;
    logic [10:0]        r_half_w;

    t_state               r_state, n_state;
    logic [9:0]           r_column;
    logic signed [27:0]   r_cam;
    logic signed [54:0]   r_prod;
    logic signed [24:0]   r_rx, r_ry;
    logic [NX_W-1:0]      r_nx, r_ny, r_last;
    logic [AB_W-1:0]      r_a, r_b;
    logic signed [CELL_W-1:0] r_cx, r_cy;
    logic                 r_side;
    logic [STEP_W-1:0]    r_step;
    logic [7:0]           r_value;
    logic [23:0]          r_perp;
    logic [15:0]          r_lh;
    logic                 r_out_valid, r_out_hit;
    logic [dwrc_pkg::OUT_TDATA_W-1:0] r_out_data;

    // request fields
    logic       in_kind;
    logic [4:0] in_tile_x, in_tile_y;
    logic [7:0] in_tile_value;
    logic [9:0] in_column;
    logic       in_accept;

    assign in_kind       = i_s_tuser;
    assign in_tile_x     = i_s_tdata[4:0];
    assign in_tile_y     = i_s_tdata[9:5];
    assign in_tile_value = i_s_tdata[17:10];
    assign in_column     = i_s_tdata[27:18];

    logic map_busy;
    logic [7:0] map_rd_data;
    logic map_wr_en;
    logic [AW-1:0] map_wr_addr, map_rd_addr;

    assign o_s_tready = (r_state == S_IDLE) && !map_busy;
    assign in_accept  = i_s_tvalid && o_s_tready;

    assign map_wr_en = in_accept && (in_kind == dwrc_pkg::KIND_LOAD) &&
                       (32'(in_tile_x) < MAP_WIDTH) && (32'(in_tile_y) < MAP_HEIGHT);
    assign map_wr_addr = AW'(32'(in_tile_y) * MAP_WIDTH + 32'(in_tile_x));

    // derived ray and position values
    logic [P_W-1:0]  px, py;
    logic [23:0]     ax, ay;
    logic [16:0]     nx0, ny0;

    always_comb begin
        px  = P_W'({8'd0, r_pos_x, 8'd0} / TILE_SIZE);
        py  = P_W'({8'd0, r_pos_y, 8'd0} / TILE_SIZE);
        ax  = r_rx[24] ? 24'(-r_rx) : r_rx[23:0];
        ay  = r_ry[24] ? 24'(-r_ry) : r_ry[23:0];
        nx0 = r_rx[24] ? {1'b0, px[15:0]} : 17'(17'h10000 - {1'b0, px[15:0]});
        ny0 = r_ry[24] ? {1'b0, py[15:0]} : 17'(17'h10000 - {1'b0, py[15:0]});
    end

    // shared multiplier, registered product
    logic signed [28:0] mul_a;
    logic signed [25:0] mul_b;

    always_comb begin
        case (r_state)
            S_MUL_RX: begin
                mul_a = 29'(r_cam);
                mul_b = 26'(r_plane_x);
            end
            S_MUL_RY: begin
                mul_a = 29'(r_cam);
                mul_b = 26'(r_plane_y);
            end
            S_MUL_A: begin
                mul_a = $signed({12'd0, nx0});
                mul_b = $signed({2'd0, ay});
            end
            S_MUL_B: begin
                mul_a = $signed({12'd0, ny0});
                mul_b = $signed({2'd0, ax});
            end
            S_MUL_TEX: begin
                mul_a = $signed({5'd0, r_perp});
                mul_b = r_side ? 26'(r_rx) : 26'(r_ry);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    logic signed [24:0] ray_new;
    assign ray_new = clamp_ray(40'($signed(r_prod[54:16])) +
                               40'(r_state == S_MUL_RY ? r_dir_x : r_dir_y));

    // walk step
    logic                     take_x, out_of_map;
    logic signed [CELL_W-1:0] nxt_cx, nxt_cy;

    always_comb begin
        take_x = (r_a < r_b);
        nxt_cx = r_cx;
        nxt_cy = r_cy;
        if (take_x)
            nxt_cx = r_rx[24] ? CELL_W'(r_cx - 1) : CELL_W'(r_cx + 1);
        else
            nxt_cy = r_ry[24] ? CELL_W'(r_cy - 1) : CELL_W'(r_cy + 1);
        out_of_map = (nxt_cx < 0) || (nxt_cy < 0) ||
                     (nxt_cx >= MAP_WIDTH) || (nxt_cy >= MAP_HEIGHT);
    end

    assign map_rd_addr = AW'(32'(nxt_cy[Y_W-1:0]) * MAP_WIDTH + 32'(nxt_cx[X_W-1:0]));

    // shared divider
    logic             div_start, div_done;
    logic [DIV_N-1:0] div_num, div_quo;
    logic [DEN_W-1:0] div_den;
    logic [23:0]      a_side;

    assign a_side = r_side ? ay : ax;

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_CAM_GO: begin
                div_start = 1'b1;
                div_num   = DIV_N'({r_column, 17'd0});
                div_den   = (r_half_w == 11'd0) ? DEN_W'(1) : DEN_W'(r_half_w);
            end
            S_PERP_GO: begin
                div_start = (a_side != 24'd0);
                div_num   = DIV_N'({r_last, 14'd0});
                div_den   = a_side;
            end
            S_LH_GO: begin
                div_start = (r_perp != 24'd0);
                div_num   = DIV_N'({r_scr_h, 16'd0});
                div_den   = r_perp;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    dwrc_div #(.NUM_W(DIV_N), .DEN_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    dwrc_map #(.DEPTH(DEPTH), .AW(AW)) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (map_wr_en),
        .i_wr_addr (map_wr_addr),
        .i_wr_data (in_tile_value),
        .i_rd_addr (map_rd_addr),
        .o_rd_data (map_rd_data),
        .o_busy    (map_busy)
    );

    // final result fields
    logic [10:0]        mid;
    logic [14:0]        half;
    logic [15:0]        draw_start, draw_end, tex_u;
    logic [15:0]        mid_sum;
    logic [P_W-1:0]     base;

    always_comb begin
        mid        = r_scr_h[11:1];
        half       = r_lh[15:1];
        draw_start = 16'({5'd0, mid} - {1'b0, half});
        mid_sum    = 16'({5'd0, mid} + {1'b0, half});
        draw_end   = mid_sum[15] ? 16'h7FFF : mid_sum;
        base       = r_side ? px : py;
        tex_u      = 16'(base[15:0] + r_prod[29:14]);
    end

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (in_accept && in_kind == dwrc_pkg::KIND_CAST) n_state = S_CAM_GO;
            S_CAM_GO:    n_state = S_CAM_WAIT;
            S_CAM_WAIT:  if (div_done) n_state = S_MUL_RX;
            S_MUL_RX:    n_state = S_MUL_RY;
            S_MUL_RY:    n_state = S_RAY_Y;
            S_RAY_Y:     n_state = S_MUL_A;
            S_MUL_A:     n_state = S_MUL_B;
            S_MUL_B:     n_state = S_START;
            S_START: begin
                if (32'(px[P_W-1:16]) < MAP_WIDTH && 32'(py[P_W-1:16]) < MAP_HEIGHT)
                    n_state = S_WALK;
                else
                    n_state = S_MISS;
            end
            S_WALK:      n_state = out_of_map ? S_MISS : S_LOOK;
            S_LOOK: begin
                if (map_rd_data != 8'd0)
                    n_state = S_PERP_GO;
                else if (r_step == STEP_W'(MAX_STEPS))
                    n_state = S_MISS;
                else
                    n_state = S_WALK;
            end
            S_MISS:      n_state = S_OUT;
            S_PERP_GO:   n_state = (a_side != 24'd0) ? S_PERP_WAIT : S_LH_GO;
            S_PERP_WAIT: if (div_done) n_state = S_LH_GO;
            S_LH_GO:     n_state = (r_perp != 24'd0) ? S_LH_WAIT : S_MUL_TEX;
            S_LH_WAIT:   if (div_done) n_state = S_MUL_TEX;
            S_MUL_TEX:   n_state = S_FINISH;
            S_FINISH:    n_state = S_OUT;
            S_OUT:       if (i_m_tready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_dir_x     <= dwrc_pkg::RST_DIR_X;
            r_dir_y     <= dwrc_pkg::RST_DIR_Y;
            r_plane_x   <= dwrc_pkg::RST_PLANE_X;
            r_plane_y   <= dwrc_pkg::RST_PLANE_Y;
            r_scr_h     <= dwrc_pkg::RST_SCREEN_H;
            r_half_w    <= dwrc_pkg::RST_HALF_W;
        end else begin
            r_state <= n_state;
            if (r_state == S_MISS || r_state == S_FINISH)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_tready)
                r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dwrc_pkg::REG_POS_X:         r_pos_x   <= i_cfg_data;
                    dwrc_pkg::REG_POS_Y:         r_pos_y   <= i_cfg_data;
                    dwrc_pkg::REG_DIR_X:         r_dir_x   <= i_cfg_data[15:0];
                    dwrc_pkg::REG_DIR_Y:         r_dir_y   <= i_cfg_data[15:0];
                    dwrc_pkg::REG_PLANE_X:       r_plane_x <= i_cfg_data[15:0];
                    dwrc_pkg::REG_PLANE_Y:       r_plane_y <= i_cfg_data[15:0];
                    dwrc_pkg::REG_SCREEN_HEIGHT: r_scr_h   <= i_cfg_data[11:0];
                    dwrc_pkg::REG_HALF_WIDTH:    r_half_w  <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_column <= in_column;
            S_CAM_WAIT: r_cam <= $signed({1'b0, div_quo[26:0]}) - 28'sd65536;
            S_MUL_RY: r_rx <= ray_new;
            S_RAY_Y:  r_ry <= ray_new;
            S_MUL_A: begin
                r_nx <= NX_W'(nx0);
                r_ny <= NX_W'(ny0);
            end
            S_MUL_B: r_a <= r_prod[AB_W-1:0];
            S_START: begin
                r_b    <= r_prod[AB_W-1:0];
                r_cx   <= CELL_W'(px[P_W-1:16]);
                r_cy   <= CELL_W'(py[P_W-1:16]);
                r_step <= '0;
                r_side <= 1'b0;
            end
            S_WALK: begin
                r_step <= r_step + 1'b1;
                r_cx   <= nxt_cx;
                r_cy   <= nxt_cy;
                if (take_x) begin
                    r_last <= r_nx;
                    r_nx   <= NX_W'(r_nx + NX_W'(17'h10000));
                    r_a    <= AB_W'(r_a + AB_W'({ay, 16'd0}));
                    r_side <= 1'b0;
                end else begin
                    r_last <= r_ny;
                    r_ny   <= NX_W'(r_ny + NX_W'(17'h10000));
                    r_b    <= AB_W'(r_b + AB_W'({ax, 16'd0}));
                    r_side <= 1'b1;
                end
            end
            S_LOOK: r_value <= map_rd_data;
            S_MISS: begin
                r_out_hit  <= 1'b0;
                r_out_data <= {102'd0, r_column};
            end
            S_PERP_GO: if (a_side == 24'd0) r_perp <= 24'hFFFFFF;
            S_PERP_WAIT: begin
                if (div_quo > DIV_N'(24'hFFFFFF))
                    r_perp <= 24'hFFFFFF;
                else
                    r_perp <= div_quo[23:0];
            end
            S_LH_GO: if (r_perp == 24'd0) r_lh <= 16'hFFFF;
            S_LH_WAIT: begin
                if (div_quo > DIV_N'(16'hFFFF))
                    r_lh <= 16'hFFFF;
                else
                    r_lh <= div_quo[15:0];
            end
            S_FINISH: begin
                r_out_hit  <= 1'b1;
                r_out_data <= {5'd0, tex_u, draw_end, draw_start, r_lh, r_perp,
                               r_value, r_side, r_column};
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_hit;

endmodule

// ===== rtl/dwrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwrc_checker
// Port level checks for the wall ray caster, bound to the top level.
// ----------------------------------------------------------------------------
module dwrc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [dwrc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic                              o_m_tuser
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // one cast in flight: no request taken while a result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("ready while result pending");

    // a cast request closes the input
    a_cast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == dwrc_pkg::KIND_CAST |=> !o_s_tready)
        else $error("ready right after cast request");

    // a miss carries only the column
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[dwrc_pkg::OUT_TDATA_W-1:10] == '0)
        else $error("miss with nonzero fields");

endmodule

bind dda_wall_ray_caster dwrc_checker u_dwrc_checker (.*);
